// ----- sv/gcdh_pkg.sv -----
package gcdh_pkg;

  localparam logic [63:0] PI_Q60     = 64'h3243_F6A8_885A_308D;
  localparam logic [63:0] INV_PI_Q64 = 64'h517C_C1B7_2722_0A94;

  typedef enum logic [1:0] {
    CLAMP_NONE = 2'd0,
    CLAMP_ZERO = 2'd1,
    CLAMP_PI   = 2'd2
  } clamp_t;

  // Shift-subtract division, used only to build constants at elaboration.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Arctangent of 2^-idx in Q62 radians from the truncated power series.
  function automatic logic [63:0] atan_q62(input int unsigned idx);
    logic [63:0] acc;
    logic [63:0] term;
    int unsigned e;
    acc  = '0;
    term = '0;
    e    = 0;
    if (idx == 0) begin
      acc = PI_Q60;
    end else begin
      for (int unsigned k = 0; k < 32; k++) begin
        e = idx * (2 * k + 1);
        if (e <= 62) begin
          term = udiv64(64'd1 << (62 - e), 64'(2 * k + 1));
          if (k[0]) acc = acc - term;
          else acc = acc + term;
        end
      end
    end
    return acc;
  endfunction

  // Inverse of the squared CORDIC gain in Q62 for the given number of iterations.
  function automatic logic [63:0] gain_sq_q62(input int unsigned steps);
    logic [63:0] g;
    g = 64'd1 << 62;
    for (int unsigned i = 0; i < 64; i++) begin
      if (i < steps && 2 * i < 63) begin
        g = g - udiv64(g, (64'd1 << (2 * i)) + 64'd1);
      end
    end
    return g;
  endfunction

endpackage

// ----- sv/gcdh_in_if.sv -----
interface gcdh_in_if;
  logic               valid;
  logic               ready;
  logic        [31:0] lon_first;
  logic signed [31:0] lat_first;
  logic        [31:0] lon_second;
  logic signed [31:0] lat_second;

  modport source(output valid, lon_first, lat_first, lon_second, lat_second, input ready);
  modport sink(input valid, lon_first, lat_first, lon_second, lat_second, output ready);
endinterface

// ----- sv/gcdh_out_if.sv -----
interface gcdh_out_if;
  logic                   valid;
  logic                   ready;
  logic            [31:0] separation;
  gcdh_pkg::clamp_t       clamp_status;

  modport source(output valid, separation, clamp_status, input ready);
  modport sink(input valid, separation, clamp_status, output ready);
endinterface

// ----- sv/great_circle_distance_haversine.sv -----
// Throughput: one transaction per cycle while the pipeline advances; every CORDIC
// iteration, square-root digit and multiplier partial-product step has its own
// register stage.
// The whole pipeline advances whenever the output register is empty or being read.
// Reset clears the valid bits only; the data registers are not reset.
module great_circle_distance_haversine #(
  parameter int unsigned ANGLE_BITS   = 32,
  parameter int unsigned CORDIC_STEPS = 32
) (
  input logic              clk,
  input logic              rst_n,
  gcdh_in_if.sink          in_chan,
  gcdh_out_if.source       out_chan
);

  localparam int unsigned AB  = ANGLE_BITS;
  localparam int unsigned CS  = CORDIC_STEPS;
  localparam int unsigned XW  = AB + 3;
  localparam int unsigned MW  = AB + 2;
  localparam int unsigned DW  = AB + 2;
  localparam int unsigned HW  = AB + 4;
  localparam int unsigned SQW = AB + 1;
  localparam int unsigned RW  = AB + 4;
  localparam int unsigned VW  = 2 * SQW;
  localparam int unsigned LAT = 2 * CS + AB + 21;

  localparam logic [63:0] GAIN_FULL = gcdh_pkg::gain_sq_q62(CS);
  localparam logic [63:0] PI_FULL   = gcdh_pkg::PI_Q60;
  localparam logic [63:0] INV_PI    = gcdh_pkg::INV_PI_Q64;
  localparam logic signed [HW-1:0] ONE_H = {{(HW-AB-1){1'b0}}, 1'b1, {AB{1'b0}}};
  localparam logic [31:0] SEP_PI = 32'h8000_0000;

  logic           adv;
  logic [LAT-1:0] vld_r;

  assign adv           = !vld_r[LAT-1] || out_chan.ready;
  assign in_chan.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_chan.valid};
    end
  end

  // Phases with 2^34 per turn, so half angles are exact.
  logic [32:0] dlon, dlat, slat;
  logic [33:0] ph_r [3];

  assign dlon = {1'b0, in_chan.lon_first} - {1'b0, in_chan.lon_second};
  assign dlat = {in_chan.lat_first[31], in_chan.lat_first}
              - {in_chan.lat_second[31], in_chan.lat_second};
  assign slat = {in_chan.lat_first[31], in_chan.lat_first}
              + {in_chan.lat_second[31], in_chan.lat_second};

  always_ff @(posedge clk) begin
    if (adv) begin
      ph_r[0] <= {dlon, 1'b0};
      ph_r[1] <= {dlat, 1'b0};
      ph_r[2] <= {slat, 1'b0};
    end
  end

  // Unit 0 gives sin^2 of half dlon, unit 1 sin^2 of half dlat, unit 2 cos^2 of half sum.
  logic [DW-1:0] sq [3];

  for (genvar u = 0; u < 3; u++) begin : g_unit
    localparam bit WANT_COS = (u == 2);
    logic [62:0]          z0;
    logic [2:0]           qd_r;
    logic signed [XW-1:0] cx_r [CS];
    logic signed [XW-1:0] cy_r [CS];
    logic signed [63:0]   cz_r [CS];
    logic                 cq_r [CS];
    logic signed [XW-1:0] xe, ye;
    logic [XW-1:0]        xa, ya;
    logic [MW-1:0]        mag_r;
    logic [DW-1:0]        sq1;

    gcdh_mul #(.AW(32), .BW(62), .SHIFT(31), .OW(63)) u_zmul (
      .clk(clk), .en(adv), .a(ph_r[u][31:0]), .b(PI_FULL[61:0]), .p(z0)
    );

    always_ff @(posedge clk) begin
      if (adv) begin
        qd_r <= {qd_r[1:0], ph_r[u][32]};
      end
    end

    for (genvar i = 0; i < CS; i++) begin : g_rot
      localparam logic signed [63:0] ATAN = signed'(gcdh_pkg::atan_q62(i));
      logic signed [XW-1:0] xi, yi;
      logic signed [63:0]   zi;
      logic                 qi;

      if (i == 0) begin : g_first
        assign xi = {{(XW-AB-1){1'b0}}, 1'b1, {AB{1'b0}}};
        assign yi = '0;
        assign zi = {1'b0, z0};
        assign qi = qd_r[2];
      end else begin : g_next
        assign xi = cx_r[i-1];
        assign yi = cy_r[i-1];
        assign zi = cz_r[i-1];
        assign qi = cq_r[i-1];
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          if (!zi[63]) begin
            cx_r[i] <= xi - (yi >>> i);
            cy_r[i] <= yi + (xi >>> i);
            cz_r[i] <= zi - ATAN;
          end else begin
            cx_r[i] <= xi + (yi >>> i);
            cy_r[i] <= yi - (xi >>> i);
            cz_r[i] <= zi + ATAN;
          end
          cq_r[i] <= qi;
        end
      end
    end

    assign xe = cx_r[CS-1];
    assign ye = cy_r[CS-1];
    assign xa = xe[XW-1] ? XW'(-xe) : XW'(xe);
    assign ya = ye[XW-1] ? XW'(-ye) : XW'(ye);

    // An odd quadrant swaps the roles of sine and cosine.
    always_ff @(posedge clk) begin
      if (adv) begin
        mag_r <= (cq_r[CS-1] ^ WANT_COS) ? xa[MW-1:0] : ya[MW-1:0];
      end
    end

    gcdh_mul #(.AW(MW), .BW(MW), .SHIFT(AB), .OW(DW)) u_sqmul (
      .clk(clk), .en(adv), .a(mag_r), .b(mag_r), .p(sq1)
    );

    gcdh_mul #(.AW(DW), .BW(62), .SHIFT(62), .OW(DW)) u_gmul (
      .clk(clk), .en(adv), .a(sq1), .b(GAIN_FULL[61:0]), .p(sq[u])
    );
  end

  // h = x*(z-y) + y, with one minus h formed alongside it.
  logic [DW-1:0]        x_r, y_r, zym_r, xm;
  logic                 zyn_r;
  logic signed [HW-1:0] omy_r;
  logic [DW-1:0]        yd_r [3];
  logic signed [HW-1:0] omyd_r [3];
  logic                 nd_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r   <= sq[0];
      y_r   <= sq[1];
      zyn_r <= sq[2] < sq[1];
      zym_r <= (sq[2] < sq[1]) ? sq[1] - sq[2] : sq[2] - sq[1];
      omy_r <= ONE_H - signed'(HW'(sq[1]));
    end
  end

  gcdh_mul #(.AW(DW), .BW(DW), .SHIFT(AB), .OW(DW)) u_hmul (
    .clk(clk), .en(adv), .a(x_r), .b(zym_r), .p(xm)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      yd_r[0]   <= y_r;
      yd_r[1]   <= yd_r[0];
      yd_r[2]   <= yd_r[1];
      omyd_r[0] <= omy_r;
      omyd_r[1] <= omyd_r[0];
      omyd_r[2] <= omyd_r[1];
      nd_r[0]   <= zyn_r;
      nd_r[1]   <= nd_r[0];
      nd_r[2]   <= nd_r[1];
    end
  end

  logic signed [HW-1:0] ye_h, me_h, hv, hcv;
  logic [SQW-1:0]       hs_r, hc_r;
  gcdh_pkg::clamp_t     hst_r;

  assign ye_h = signed'(HW'(yd_r[2]));
  assign me_h = signed'(HW'(xm));
  assign hv   = nd_r[2] ? ye_h - me_h : ye_h + me_h;
  assign hcv  = nd_r[2] ? omyd_r[2] + me_h : omyd_r[2] - me_h;

  always_ff @(posedge clk) begin
    if (adv) begin
      hs_r <= hv[SQW-1:0];
      hc_r <= hcv[SQW-1:0];
      if (hv[HW-1]) begin
        hst_r <= gcdh_pkg::CLAMP_ZERO;
      end else if (hv >= ONE_H) begin
        hst_r <= gcdh_pkg::CLAMP_PI;
      end else begin
        hst_r <= gcdh_pkg::CLAMP_NONE;
      end
    end
  end

  // Digit-by-digit square roots: lane 0 gives sqrt(h), lane 1 gives sqrt(1-h).
  logic [RW-1:0]    rem_r  [2][SQW];
  logic [SQW-1:0]   root_r [2][SQW];
  logic [VW-1:0]    rad_r  [2][SQW];
  gcdh_pkg::clamp_t sst_r  [SQW];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [SQW-1:0] sqin;
    assign sqin = (l == 0) ? hs_r : hc_r;

    for (genvar j = 0; j < SQW; j++) begin : g_dig
      logic [RW-1:0]  ri, r2, trial;
      logic [SQW-1:0] rti;
      logic [VW-1:0]  rdi;

      if (j == 0) begin : g_first
        assign ri  = '0;
        assign rti = '0;
        assign rdi = {1'b0, sqin, {AB{1'b0}}};
      end else begin : g_next
        assign ri  = rem_r[l][j-1];
        assign rti = root_r[l][j-1];
        assign rdi = rad_r[l][j-1];
      end

      assign r2    = {ri[RW-3:0], rdi[VW-1:VW-2]};
      assign trial = {1'b0, rti, 2'b01};

      always_ff @(posedge clk) begin
        if (adv) begin
          if (r2 >= trial) begin
            rem_r[l][j]  <= r2 - trial;
            root_r[l][j] <= {rti[SQW-2:0], 1'b1};
          end else begin
            rem_r[l][j]  <= r2;
            root_r[l][j] <= {rti[SQW-2:0], 1'b0};
          end
          rad_r[l][j] <= {rdi[VW-3:0], 2'b00};
        end
      end
    end
  end

  for (genvar j = 0; j < SQW; j++) begin : g_sst
    always_ff @(posedge clk) begin
      if (adv) begin
        sst_r[j] <= (j == 0) ? hst_r : sst_r[(j == 0) ? 0 : j - 1];
      end
    end
  end

  // Vectoring CORDIC on (sqrt(1-h), sqrt(h)) accumulates asin(sqrt(h)).
  logic signed [XW-1:0] vx_r [CS];
  logic signed [XW-1:0] vy_r [CS];
  logic signed [63:0]   va_r [CS];
  gcdh_pkg::clamp_t     vst_r [CS];

  for (genvar i = 0; i < CS; i++) begin : g_vec
    localparam logic signed [63:0] ATAN = signed'(gcdh_pkg::atan_q62(i));
    logic signed [XW-1:0] xi, yi;
    logic signed [63:0]   ai;
    gcdh_pkg::clamp_t     si;

    if (i == 0) begin : g_first
      assign xi = signed'(XW'(root_r[1][SQW-1]));
      assign yi = signed'(XW'(root_r[0][SQW-1]));
      assign ai = '0;
      assign si = sst_r[SQW-1];
    end else begin : g_next
      assign xi = vx_r[i-1];
      assign yi = vy_r[i-1];
      assign ai = va_r[i-1];
      assign si = vst_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (!yi[XW-1]) begin
          vx_r[i] <= xi + (yi >>> i);
          vy_r[i] <= yi - (xi >>> i);
          va_r[i] <= ai + ATAN;
        end else begin
          vx_r[i] <= xi - (yi >>> i);
          vy_r[i] <= yi + (xi >>> i);
          va_r[i] <= ai - ATAN;
        end
        vst_r[i] <= si;
      end
    end
  end

  logic [62:0]      a_pos;
  logic [32:0]      sep_raw;
  gcdh_pkg::clamp_t fst_r [3];

  assign a_pos = va_r[CS-1][63] ? '0 : va_r[CS-1][62:0];

  gcdh_mul #(.AW(63), .BW(64), .SHIFT(94), .OW(33)) u_smul (
    .clk(clk), .en(adv), .a(a_pos), .b(INV_PI), .p(sep_raw)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      fst_r[0] <= vst_r[CS-1];
      fst_r[1] <= fst_r[0];
      fst_r[2] <= fst_r[1];
    end
  end

  logic [31:0]      out_sep_r;
  gcdh_pkg::clamp_t out_st_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      case (fst_r[2])
        gcdh_pkg::CLAMP_ZERO: out_sep_r <= '0;
        gcdh_pkg::CLAMP_PI:   out_sep_r <= SEP_PI;
        default:              out_sep_r <= (sep_raw > {1'b0, SEP_PI}) ? SEP_PI : sep_raw[31:0];
      endcase
      out_st_r <= fst_r[2];
    end
  end

  assign out_chan.valid        = vld_r[LAT-1];
  assign out_chan.separation   = out_sep_r;
  assign out_chan.clamp_status = out_st_r;

`ifndef SYNTH
  a_pi_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.clamp_status == gcdh_pkg::CLAMP_PI
      |-> out_chan.separation == SEP_PI)
    else $error("clamp to pi without a separation of pi");

  a_sep_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> out_chan.separation <= SEP_PI)
    else $error("separation above pi");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline valid bits moved during a stall");

  a_accept_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> vld_r[0])
    else $error("accepted transaction did not enter the pipeline");
`endif

endmodule

// ----- sv/gcdh_mul.sv -----
module gcdh_mul #(
  parameter int unsigned AW    = 32,
  parameter int unsigned BW    = 32,
  parameter int unsigned SHIFT = 32,
  parameter int unsigned OW    = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [AW-1:0] a,
  input  logic [BW-1:0] b,
  output logic [OW-1:0] p
);

  localparam logic [128:0] RND = 129'd1 << (SHIFT - 1);

  logic [63:0]  a64, b64;
  logic [63:0]  ll_r, lh_r, hl_r, hh_r;
  logic [127:0] sum_r;
  logic [128:0] rnd;
  logic [OW-1:0] p_r;

  assign a64 = 64'(a);
  assign b64 = 64'(b);

  // Four 32 by 32 partial products, then their sum, then rounding.
  always_ff @(posedge clk) begin
    if (en) begin
      ll_r  <= a64[31:0] * b64[31:0];
      lh_r  <= a64[31:0] * b64[63:32];
      hl_r  <= a64[63:32] * b64[31:0];
      hh_r  <= a64[63:32] * b64[63:32];
      sum_r <= {hh_r, 64'd0} + {32'd0, lh_r, 32'd0} + {32'd0, hl_r, 32'd0} + {64'd0, ll_r};
      p_r   <= rnd[SHIFT+OW-1:SHIFT];
    end
  end

  assign rnd = {1'b0, sum_r} + RND;
  assign p   = p_r;

endmodule
